// File: design/pts_pkg.sv
// Package for the process table scheduler: codes, widths and shared types.
// Depends on nothing; used by pts_ctrl, pts_dp and process_table_scheduler.
package pts_pkg;

    localparam int TableDepthDefault = 16;
    localparam int RatioFracDefault  = 12;

    localparam logic [2:0] FUNC_START = 3'd0;
    localparam logic [2:0] FUNC_END   = 3'd1;
    localparam logic [2:0] FUNC_RATE  = 3'd2;
    localparam logic [2:0] FUNC_TICK  = 3'd3;
    localparam logic [2:0] FUNC_SCHED = 3'd4;

    localparam logic [2:0] POL_FIRST = 3'd0;
    localparam logic [2:0] POL_FIFO  = 3'd1;
    localparam logic [2:0] POL_LIFO  = 3'd2;
    localparam logic [2:0] POL_RR    = 3'd3;
    localparam logic [2:0] POL_SHARE = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_REJECT   = 2'd3;

    localparam logic [6:0] BUDGET = 7'd100;

    typedef struct packed {
        logic start;     // latch item, clear scan state
        logic scan;      // examine slot at scan index
        logic apply;     // commit the event after the scan
        logic div_start; // launch one ratio division
        logic div_store; // write back quotient
        logic next_slot; // advance tick slot
    } pts_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic slot_div;   // tick slot needs a division
        logic div_done;
        logic tick_last;
        logic is_tick;
    } pts_stat_t;

endpackage

// File: design/pts_div.sv
// Restoring divider, one quotient bit per cycle, for the ratio update.
// Depends on nothing; instanced by pts_dp.
module pts_div
#(
    parameter int NW = 51,
    parameter int DW = 39
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [DW:0]   r_reg;
    logic [NW-1:0] n_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic [DW:0]   shifted;

    assign shifted = {r_reg[DW-1:0], n_reg[NW-1]};
    assign trial   = shifted - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            n_reg <= num;
            d_reg <= den;
            r_reg <= '0;
            q_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg <= {n_reg[NW-2:0], 1'b0};
            if (!trial[DW])
            begin
                r_reg <= trial;
                q_reg <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= shifted;
                q_reg <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;
endmodule

// File: design/pts_ctrl.sv
// Controller state machine for the process table scheduler.
// Depends on pts_pkg for command and status structs.
module pts_ctrl
    import pts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_fire,
    input  logic      out_busy,
    input  pts_stat_t stat,
    output pts_cmd_t  cmd,
    output logic      idle,
    output logic      emit
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_APPLY = 6'b000100,
        S_TCHK  = 6'b001000,
        S_TDIV  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd  = '0;
        emit = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_last)
                    state_next = stat.is_tick ? S_TCHK : S_APPLY;
            end
            S_TCHK:
            begin
                if (stat.slot_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_TDIV;
                end
                else
                begin
                    cmd.next_slot = 1'b1;
                    if (stat.tick_last)
                        state_next = S_APPLY;
                end
            end
            S_TDIV:
            begin
                if (stat.div_done)
                begin
                    cmd.div_store = 1'b1;
                    cmd.next_slot = 1'b1;
                    state_next    = stat.tick_last ? S_APPLY : S_TCHK;
                end
            end
            S_APPLY:
            begin
                if (!out_busy)
                begin
                    cmd.apply  = 1'b1;
                    emit       = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == S_IDLE);

    ap_div_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TDIV) |-> stat.is_tick)
        else $error("division outside tick");
    ap_emit_apply: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (state_reg == S_APPLY))
        else $error("emit outside apply");
    ap_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (state_reg == S_SCAN))
        else $error("start did not enter scan");
endmodule

// File: design/pts_dp.sv
// Datapath: process table registers, sequential scan and event update.
// Depends on pts_pkg and pts_div.
module pts_dp
    import pts_pkg::*;
#(
    parameter int TABLE_DEPTH     = TableDepthDefault,
    parameter int RATIO_FRAC_BITS = RatioFracDefault
)(
    input  logic        clk,
    input  logic        rst_n,
    input  pts_cmd_t    cmd,
    input  logic [2:0]  policy,
    input  logic [2:0]  func,
    input  logic [15:0] proc_id,
    input  logic [6:0]  rate_percent,
    output pts_stat_t   stat,
    output logic [1:0]  res_status,
    output logic [15:0] res_chosen,
    output logic        res_resched
);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int RW = 8 + RATIO_FRAC_BITS;
    localparam int PW = 32 + 7;
    localparam int NW = PW + RATIO_FRAC_BITS;
    localparam int DW = 39;
    localparam logic [RW-1:0] RATIO_MAX = '1;
    localparam logic [RW-1:0] ONE   = RW'(1) << RATIO_FRAC_BITS;
    localparam logic [RW-1:0] THREE = RW'(3) << RATIO_FRAC_BITS;

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [15:0] id_reg    [TABLE_DEPTH];
    logic [31:0] order_reg [TABLE_DEPTH];
    logic [6:0]  rate_reg  [TABLE_DEPTH];
    logic [31:0] run_reg   [TABLE_DEPTH];
    logic [31:0] stay_reg  [TABLE_DEPTH];
    logic [RW-1:0] ratio_reg [TABLE_DEPTH];
    logic [IW-1:0] rr_reg;
    logic          rr_none_reg;
    logic [6:0]    used_reg;
    logic [31:0]   arr_reg;

    logic [2:0]  func_reg, pol_reg;
    logic [15:0] pid_reg;
    logic [6:0]  rq_reg;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] rr_idx;
    logic [IW:0]   rr_sum;

    // scan results
    logic          free_f_reg, match_f_reg, first_f_reg, ord_f_reg, rr_f_reg;
    logic [IW-1:0] free_i_reg, match_i_reg, first_i_reg, ord_i_reg, rr_i_reg;
    logic [31:0]   ord_v_reg;
    logic          low_f_reg, mid_f_reg, idle_f_reg, fb_f_reg;
    logic [IW-1:0] low_i_reg, mid_i_reg, idle_i_reg, fb_i_reg;
    logic [RW-1:0] min1_reg, min3_reg;
    logic [31:0]   minrun_reg;
    logic [6:0]    best_reg;

    logic          div_go;
    logic          div_done;
    logic [NW-1:0] div_q;
    logic [NW-1:0] num;
    logic [DW-1:0] den;
    logic [31:0]   stay_inc;

    assign rr_sum = {1'b0, rr_reg} + {1'b0, idx_reg} + (IW+1)'(1);
    assign rr_idx = rr_none_reg ? idx_reg :
                    (rr_sum >= (IW+1)'(TABLE_DEPTH)) ? IW'(rr_sum - (IW+1)'(TABLE_DEPTH))
                                                     : IW'(rr_sum);

    assign stat.scan_last = (idx_reg == IW'(TABLE_DEPTH - 1));
    assign stat.tick_last = (idx_reg == IW'(TABLE_DEPTH - 1));
    assign stat.is_tick   = (func_reg == FUNC_TICK);
    assign stat.slot_div  = valid_reg[idx_reg] && (rate_reg[idx_reg] != 7'd0);
    assign stat.div_done  = div_done;

    assign stay_inc = (stay_reg[idx_reg] == '1) ? stay_reg[idx_reg] : stay_reg[idx_reg] + 1'b1;
    assign num = {PW'(run_reg[idx_reg]) * PW'(BUDGET), {RATIO_FRAC_BITS{1'b0}}};
    assign den = DW'(stay_inc) * DW'(rate_reg[idx_reg]);
    assign div_go = cmd.div_start;

    pts_div #(.NW(NW), .DW(DW)) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (div_go),
        .num  (num),
        .den  (den),
        .done (div_done),
        .quo  (div_q)
    );

    // event decision
    logic          chose_f;
    logic [IW-1:0] chose_i;
    logic          set_rr, inc_run;
    logic [6:0]    base;
    logic [7:0]    newsum;

    always_comb
    begin
        chose_f = 1'b0;
        chose_i = '0;
        set_rr  = 1'b0;
        inc_run = 1'b0;
        case (pol_reg)
            POL_FIRST:
            begin
                chose_f = first_f_reg;
                chose_i = first_i_reg;
            end
            POL_FIFO, POL_LIFO:
            begin
                chose_f = ord_f_reg;
                chose_i = ord_i_reg;
                set_rr  = ord_f_reg;
            end
            POL_RR:
            begin
                chose_f = rr_f_reg;
                chose_i = rr_i_reg;
                set_rr  = rr_f_reg;
            end
            POL_SHARE:
            begin
                inc_run = 1'b1;
                if (low_f_reg)
                begin
                    chose_f = 1'b1;
                    chose_i = low_i_reg;
                end
                else if (idle_f_reg)
                begin
                    chose_f = 1'b1;
                    chose_i = idle_i_reg;
                end
                else if (mid_f_reg)
                begin
                    chose_f = 1'b1;
                    chose_i = mid_i_reg;
                end
                else
                begin
                    chose_f = fb_f_reg;
                    chose_i = fb_i_reg;
                end
            end
            default:
            begin
                chose_f = 1'b0;
            end
        endcase
    end

    assign base   = (used_reg > rate_reg[match_i_reg]) ? used_reg - rate_reg[match_i_reg] : 7'd0;
    assign newsum = {1'b0, base} + {1'b0, rq_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rr_reg      <= '0;
            rr_none_reg <= 1'b1;
            used_reg    <= '0;
            arr_reg     <= 32'd1;
            idx_reg     <= '0;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                rate_reg[i]  <= '0;
                run_reg[i]   <= '0;
                stay_reg[i]  <= '0;
                ratio_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.start)
            begin
                idx_reg <= '0;
                free_f_reg <= 1'b0; match_f_reg <= 1'b0; first_f_reg <= 1'b0;
                ord_f_reg <= 1'b0; rr_f_reg <= 1'b0;
                low_f_reg <= 1'b0; mid_f_reg <= 1'b0; idle_f_reg <= 1'b0;
                fb_f_reg <= 1'b0;
                min1_reg <= ONE; min3_reg <= THREE;
            end
            if (cmd.scan)
            begin
                idx_reg <= stat.scan_last ? '0 : idx_reg + 1'b1;
                if (!valid_reg[idx_reg] && !free_f_reg)
                begin
                    free_f_reg <= 1'b1;
                    free_i_reg <= idx_reg;
                end
                if (valid_reg[idx_reg])
                begin
                    if (!match_f_reg && id_reg[idx_reg] == pid_reg)
                    begin
                        match_f_reg <= 1'b1;
                        match_i_reg <= idx_reg;
                    end
                    if (!first_f_reg)
                    begin
                        first_f_reg <= 1'b1;
                        first_i_reg <= idx_reg;
                    end
                    if (!ord_f_reg ||
                        (pol_reg == POL_FIFO ? order_reg[idx_reg] < ord_v_reg
                                             : order_reg[idx_reg] > ord_v_reg))
                    begin
                        ord_f_reg <= 1'b1;
                        ord_i_reg <= idx_reg;
                        ord_v_reg <= order_reg[idx_reg];
                    end
                    if (!fb_f_reg || rate_reg[idx_reg] > best_reg)
                    begin
                        fb_f_reg <= 1'b1;
                        fb_i_reg <= idx_reg;
                        best_reg <= rate_reg[idx_reg];
                    end
                    if (rate_reg[idx_reg] != 7'd0)
                    begin
                        if (ratio_reg[idx_reg] < min1_reg)
                        begin
                            min1_reg  <= ratio_reg[idx_reg];
                            low_f_reg <= 1'b1;
                            low_i_reg <= idx_reg;
                        end
                        else if (ratio_reg[idx_reg] < min3_reg)
                        begin
                            min3_reg  <= ratio_reg[idx_reg];
                            mid_f_reg <= 1'b1;
                            mid_i_reg <= idx_reg;
                        end
                    end
                    else if (!idle_f_reg || run_reg[idx_reg] < minrun_reg)
                    begin
                        idle_f_reg <= 1'b1;
                        idle_i_reg <= idx_reg;
                        minrun_reg <= run_reg[idx_reg];
                    end
                end
                if (valid_reg[rr_idx] && !rr_f_reg)
                begin
                    rr_f_reg <= 1'b1;
                    rr_i_reg <= rr_idx;
                end
            end
            if (cmd.next_slot)
            begin
                idx_reg <= stat.tick_last ? '0 : idx_reg + 1'b1;
                if (valid_reg[idx_reg])
                    stay_reg[idx_reg] <= stay_inc;
            end
            if (cmd.div_store)
                ratio_reg[idx_reg] <= (div_q > NW'(RATIO_MAX)) ? RATIO_MAX : RW'(div_q);
            if (cmd.apply)
            begin
                case (func_reg)
                    FUNC_START:
                    begin
                        if (free_f_reg)
                        begin
                            valid_reg[free_i_reg] <= 1'b1;
                            rate_reg[free_i_reg]  <= '0;
                            arr_reg <= arr_reg + 1'b1;
                        end
                    end
                    FUNC_END:
                    begin
                        if (match_f_reg)
                        begin
                            valid_reg[match_i_reg] <= 1'b0;
                            used_reg <= base;
                        end
                    end
                    FUNC_RATE:
                    begin
                        if (match_f_reg && newsum <= {1'b0, BUDGET})
                        begin
                            used_reg <= newsum[6:0];
                            rate_reg[match_i_reg] <= rq_reg;
                            for (int i = 0; i < TABLE_DEPTH; i++)
                            begin
                                run_reg[i]  <= '0;
                                stay_reg[i] <= '0;
                            end
                        end
                    end
                    FUNC_SCHED:
                    begin
                        if (set_rr)
                        begin
                            rr_reg      <= chose_i;
                            rr_none_reg <= 1'b0;
                        end
                        if (inc_run && chose_f && run_reg[chose_i] != '1)
                            run_reg[chose_i] <= run_reg[chose_i] + 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            func_reg <= func;
            pol_reg  <= policy;
            pid_reg  <= proc_id;
            rq_reg   <= rate_percent;
        end
        if (cmd.apply && func_reg == FUNC_START && free_f_reg)
        begin
            id_reg[free_i_reg]    <= pid_reg;
            order_reg[free_i_reg] <= arr_reg;
        end
    end

    always_comb
    begin
        res_status  = ST_OK;
        res_chosen  = '0;
        res_resched = 1'b0;
        case (func_reg)
            FUNC_START:
            begin
                res_status  = free_f_reg ? ST_OK : ST_FULL;
                res_resched = free_f_reg && (pol_reg == POL_LIFO);
            end
            FUNC_END:
                res_status = match_f_reg ? ST_OK : ST_NOTFOUND;
            FUNC_RATE:
                res_status = !match_f_reg ? ST_NOTFOUND :
                             (newsum > {1'b0, BUDGET}) ? ST_REJECT : ST_OK;
            FUNC_TICK:
                res_resched = (pol_reg == POL_RR) || (pol_reg == POL_SHARE);
            FUNC_SCHED:
                res_chosen = chose_f ? id_reg[chose_i] : 16'd0;
            default:
            begin
            end
        endcase
    end

    ap_used_budget: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= BUDGET)
        else $error("budget exceeded");
    ap_rr_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.apply && set_rr) |-> valid_reg[chose_i])
        else $error("scheduled invalid slot");
    ap_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.apply && func_reg == FUNC_START && free_f_reg) |-> !valid_reg[free_i_reg])
        else $error("start into used slot");
endmodule

// File: design/process_table_scheduler.sv
// Process table scheduler top level: handshakes, policy register, output word.
// Depends on pts_pkg, pts_ctrl and pts_dp.
// A word is scanned over every slot, then applied and registered to m_tvalid once the
// output is free; a tick also runs one divide (NW = 39 + RATIO_FRAC_BITS) per valid slot
// with nonzero rate. One word at a time: none is taken until the last has been emitted.
// Reset (async, rst_n low): table empty, policy 4, arrival counter 1.
module process_table_scheduler
    import pts_pkg::*;
#(
    parameter int TABLE_DEPTH     = TableDepthDefault,
    parameter int RATIO_FRAC_BITS = RatioFracDefault
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // func[2:0], proc_id[18:3], rate_percent[25:19]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // status[1:0], chosen_id[17:2], resched[18]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data
);
    logic [2:0]  policy_reg;
    logic        ovalid_reg;
    logic [18:0] odata_reg;
    pts_cmd_t    cmd;
    pts_stat_t   stat;
    logic        idle, emit, in_fire;
    logic [1:0]  r_status;
    logic [15:0] r_chosen;
    logic        r_resched;

    assign s_tready  = idle;
    assign in_fire   = s_tvalid && idle;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_SHARE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                policy_reg <= cfg_data;
            if (emit)
                ovalid_reg <= 1'b1;
            else if (m_tready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            odata_reg <= {r_resched, r_chosen, r_status};
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {5'd0, odata_reg};

    pts_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .out_busy(ovalid_reg && !m_tready),
        .stat    (stat),
        .cmd     (cmd),
        .idle    (idle),
        .emit    (emit)
    );

    pts_dp #(.TABLE_DEPTH(TABLE_DEPTH), .RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .policy      (policy_reg),
        .func        (s_tdata[2:0]),
        .proc_id     (s_tdata[18:3]),
        .rate_percent(s_tdata[25:19]),
        .stat        (stat),
        .res_status  (r_status),
        .res_chosen  (r_chosen),
        .res_resched (r_resched)
    );
endmodule

// File: tb/sv/testbench.sv
// Testbench for process_table_scheduler: directed table then random event words,
// each checked against a listed verdict or an in-bench model of the process table. Needs pts_pkg.
module testbench
    import pts_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam int FRAC  = 12;
    localparam logic [19:0] RATIO_SAT = 20'hFFFFF;
    localparam int LIMIT = 8000000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_data;

    process_table_scheduler DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] chosen;
        logic        resched;
    } verdict_t;

    typedef struct {
        logic [2:0]  func;
        logic [15:0] pid;
        logic [6:0]  rate;
        logic        known;
        verdict_t    want;
    } row_t;

    logic [2:0]  pol;
    logic        t_valid [DEPTH];
    logic [15:0] t_id    [DEPTH];
    logic [31:0] t_order [DEPTH];
    logic [6:0]  t_rate  [DEPTH];
    logic [31:0] t_run   [DEPTH];
    logic [31:0] t_stay  [DEPTH];
    logic [19:0] t_ratio [DEPTH];
    int          rr_ptr;
    logic [6:0]  used;
    logic [31:0] arrival;

    verdict_t pending[$];
    int  errors = 0;
    int  cycles = 0;
    int  out_wait = 0;
    logic [15:0] live_ids[$];

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [31:0] sat_up(logic [31:0] v);
        return (v == 32'hFFFFFFFF) ? v : v + 32'd1;
    endfunction

    function automatic int lookup(logic [15:0] pid);
        for (int i = 0; i < DEPTH; i++)
            if (t_valid[i] && t_id[i] == pid)
                return i;
        return -1;
    endfunction

    function automatic void table_clear();
        pol = POL_SHARE;
        for (int i = 0; i < DEPTH; i++)
        begin
            t_valid[i] = 1'b0; t_id[i] = '0; t_order[i] = '0; t_rate[i] = '0;
            t_run[i] = '0; t_stay[i] = '0; t_ratio[i] = '0;
        end
        rr_ptr = -1;
        used = '0;
        arrival = 32'd1;
    endfunction

    function automatic logic [15:0] claim(int i);
        t_run[i] = sat_up(t_run[i]);
        return t_id[i];
    endfunction

    function automatic logic [15:0] share_pick();
        logic [19:0] min1, min3;
        logic [6:0]  best;
        logic [31:0] min_run;
        int lo, mid, fb, idle;
        min1 = 20'd1 << FRAC; min3 = 20'd3 << FRAC; best = '0; min_run = '0;
        lo = -1; mid = -1; fb = -1; idle = -1;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (!t_valid[i])
                continue;
            if (fb < 0 || t_rate[i] > best)
            begin
                fb = i; best = t_rate[i];
            end
            if (t_rate[i] != 0)
            begin
                if (t_ratio[i] < min1)
                begin
                    min1 = t_ratio[i]; lo = i;
                end
                else if (t_ratio[i] < min3)
                begin
                    min3 = t_ratio[i]; mid = i;
                end
            end
            else if (idle < 0 || t_run[i] < min_run)
            begin
                min_run = t_run[i]; idle = i;
            end
        end
        if (lo >= 0) return claim(lo);
        if (idle >= 0) return claim(idle);
        if (mid >= 0) return claim(mid);
        if (fb >= 0) return claim(fb);
        return 16'd0;
    endfunction

    function automatic logic [15:0] choose();
        int k;
        k = -1;
        case (pol)
            POL_FIRST:
            begin
                for (int i = 0; i < DEPTH; i++)
                    if (t_valid[i])
                        return t_id[i];
                return 16'd0;
            end
            POL_FIFO, POL_LIFO:
            begin
                for (int i = 0; i < DEPTH; i++)
                    if (t_valid[i] && (k < 0 || (pol == POL_FIFO ? t_order[i] < t_order[k]
                                                                 : t_order[i] > t_order[k])))
                        k = i;
                if (k < 0)
                    return 16'd0;
                rr_ptr = k;
                return t_id[k];
            end
            POL_RR:
            begin
                for (int i = 1; i <= DEPTH; i++)
                begin
                    k = (rr_ptr + i + DEPTH) % DEPTH;
                    if (t_valid[k])
                    begin
                        rr_ptr = k;
                        return t_id[k];
                    end
                end
                return 16'd0;
            end
            POL_SHARE: return share_pick();
            default: return 16'd0;
        endcase
    endfunction

    function automatic void advance_timer();
        logic [63:0] num, den, q;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (!t_valid[i])
                continue;
            t_stay[i] = sat_up(t_stay[i]);
            if (t_rate[i] != 0)
            begin
                num = (64'(t_run[i]) * 64'd100) << FRAC;
                den = 64'(t_stay[i]) * 64'(t_rate[i]);
                q = (den != 0) ? num / den : 64'(RATIO_SAT);
                t_ratio[i] = (q > 64'(RATIO_SAT)) ? RATIO_SAT : q[19:0];
            end
        end
    endfunction

    function automatic verdict_t apply_event(logic [2:0] func, logic [15:0] pid,
                                             logic [6:0] rate);
        verdict_t v;
        int i;
        logic [7:0] base;
        v = '0;
        case (func)
            FUNC_START:
            begin
                v.status = ST_FULL;
                for (i = 0; i < DEPTH; i++)
                    if (!t_valid[i])
                    begin
                        t_valid[i] = 1'b1; t_id[i] = pid; t_order[i] = arrival;
                        arrival = arrival + 32'd1; t_rate[i] = '0;
                        v.status = ST_OK;
                        v.resched = (pol == POL_LIFO);
                        break;
                    end
            end
            FUNC_END:
            begin
                i = lookup(pid);
                if (i < 0)
                    v.status = ST_NOTFOUND;
                else
                begin
                    t_valid[i] = 1'b0;
                    used = (used > t_rate[i]) ? used - t_rate[i] : 7'd0;
                end
            end
            FUNC_RATE:
            begin
                i = lookup(pid);
                if (i < 0)
                    v.status = ST_NOTFOUND;
                else
                begin
                    base = (used > t_rate[i]) ? 8'(used - t_rate[i]) : 8'd0;
                    if (base + 8'(rate) > 8'(BUDGET))
                        v.status = ST_REJECT;
                    else
                    begin
                        used = 7'(base + 8'(rate));
                        t_rate[i] = rate;
                        for (int j = 0; j < DEPTH; j++)
                        begin
                            t_run[j] = '0; t_stay[j] = '0;
                        end
                    end
                end
            end
            FUNC_TICK:
            begin
                advance_timer();
                v.resched = (pol == POL_RR || pol == POL_SHARE);
            end
            FUNC_SCHED: v.chosen = choose();
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_word(logic [2:0] func, logic [15:0] pid, logic [6:0] rate,
                             logic known = 1'b0, verdict_t want = '0);
        int gap;
        verdict_t pred;
        gap = $urandom_range(0, 4);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pred = apply_event(func, pid, rate);
        pending.push_back(known ? want : pred);
        s_tdata  <= {6'd0, rate, pid, func};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic set_policy(logic [2:0] p);
        s_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
        repeat (DEPTH * 40) @(posedge clk);
        cfg_data  <= p;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        pol = p;
    endtask

    always @(posedge clk)
    begin
        verdict_t got, want;
        if (m_tvalid && m_tready)
        begin
            got = {m_tdata[1:0], m_tdata[17:2], m_tdata[18]};
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = pending.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: status %0d/%0d chosen %h/%h resched %0d/%0d",
                                 want.status, got.status, want.chosen, got.chosen,
                                 want.resched, got.resched);
                end
            end
            out_wait = $urandom_range(0, 4);
        end
        else if (m_tvalid && out_wait > 0)
            out_wait--;
        m_tready <= (out_wait == 0);
    end

    row_t rows [21];
    logic [2:0] f;
    logic [15:0] p;

    initial
    begin
        rst_n = 1'b0; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        cfg_valid = 1'b0; cfg_data = '0;
        table_clear();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows = '{
            '{FUNC_SCHED, 16'h0000, 7'd0,   1, '{ST_OK, 16'h0000, 1'b0}},
            '{FUNC_END,   16'hFFFF, 7'd0,   1, '{ST_NOTFOUND, 16'h0000, 1'b0}},
            '{FUNC_RATE,  16'h1234, 7'd5,   1, '{ST_NOTFOUND, 16'h0000, 1'b0}},
            '{FUNC_START, 16'hFFFF, 7'd127, 1, '{ST_OK, 16'h0000, 1'b0}},
            '{FUNC_START, 16'h0000, 7'd0,   0, '0},
            '{FUNC_START, 16'hFFFF, 7'd0,   0, '0},
            '{FUNC_RATE,  16'hFFFF, 7'd127, 1, '{ST_REJECT, 16'h0000, 1'b0}},
            '{FUNC_RATE,  16'hFFFF, 7'd101, 1, '{ST_REJECT, 16'h0000, 1'b0}},
            '{FUNC_RATE,  16'hFFFF, 7'd100, 1, '{ST_OK, 16'h0000, 1'b0}},
            '{FUNC_RATE,  16'h0000, 7'd1,   1, '{ST_REJECT, 16'h0000, 1'b0}},
            '{FUNC_TICK,  16'h0000, 7'd0,   1, '{ST_OK, 16'h0000, 1'b1}},
            '{FUNC_SCHED, 16'h0000, 7'd0,   0, '0},
            '{FUNC_TICK,  16'h0000, 7'd0,   0, '0},
            '{FUNC_SCHED, 16'h0000, 7'd0,   0, '0},
            '{3'd5,       16'hAAAA, 7'h55,  1, '{ST_OK, 16'h0000, 1'b0}},
            '{3'd7,       16'h5555, 7'h2A,  1, '{ST_OK, 16'h0000, 1'b0}},
            '{FUNC_END,   16'hFFFF, 7'd0,   0, '0},
            '{FUNC_SCHED, 16'h0000, 7'd0,   0, '0},
            '{FUNC_RATE,  16'h0000, 7'd60,  0, '0},
            '{FUNC_TICK,  16'h0000, 7'd0,   0, '0},
            '{FUNC_SCHED, 16'h0000, 7'd0,   0, '0}
        };
        foreach (rows[r])
            send_word(rows[r].func, rows[r].pid, rows[r].rate, rows[r].known, rows[r].want);
        for (int i = 0; i < 14; i++)
            send_word(FUNC_START, 16'(i + 1), 7'd0);
        send_word(FUNC_START, 16'h0100, 7'd0);
        for (int ph = 0; ph < 8; ph++)
        begin
            set_policy(ph == 5 ? 3'd7 : ph == 6 ? 3'd5 : 3'(ph % 5));
            for (int n = 0; n < 205; n++)
            begin
                int r;
                r = $urandom_range(0, 99);
                live_ids.delete();
                for (int i = 0; i < DEPTH; i++)
                    if (t_valid[i])
                        live_ids.push_back(t_id[i]);
                p = (live_ids.size() != 0 && r % 4 != 0)
                    ? live_ids[$urandom_range(0, live_ids.size() - 1)]
                    : (r % 8 == 0 ? 16'($urandom) : 16'($urandom_range(0, 20)));
                if (r < 15)      f = FUNC_START;
                else if (r < 25) f = FUNC_END;
                else if (r < 40) f = FUNC_RATE;
                else if (r < 65) f = FUNC_TICK;
                else if (r < 97) f = FUNC_SCHED;
                else             f = 3'($urandom_range(5, 7));
                send_word(f, p, (r % 5 == 0) ? 7'($urandom) : 7'($urandom_range(0, 40)));
            end
        end
        s_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
        repeat (DEPTH * 40) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
